// File: src/vfao_pkg.sv
// ----------------------------------------------------------------------------
// vfao_pkg
// Shared widths, register codes, configuration and issue types, and the
// per-face vertex neighbour table of the voxel face AO shader.
// ----------------------------------------------------------------------------
package vfao_pkg;

  localparam int unsigned MaskW   = 27;
  localparam int unsigned FaceW   = 3;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned LevelW  = 10;
  localparam int unsigned VtxW    = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned TapW    = 5;
  localparam int unsigned NumChan = 3;
  localparam int unsigned NumFace = 6;
  localparam int unsigned NumVtx  = 4;
  localparam int unsigned FracW   = 16;
  localparam int unsigned ProdW   = ChanW + LevelW;
  localparam int unsigned FullW   = ProdW + LevelW;
  localparam int unsigned ShiftW  = FullW - FracW;

  localparam logic [VtxW-1:0] LastVtx = VtxW'(NumVtx - 1);

  localparam logic [LevelW-1:0] LevelNoneRst = LevelW'(256);
  localparam logic [LevelW-1:0] LevelOneRst  = LevelW'(205);
  localparam logic [LevelW-1:0] LevelTwoRst  = LevelW'(154);
  localparam logic [LevelW-1:0] LevelFullRst = LevelW'(102);
  localparam logic [LevelW-1:0] GainRst      = LevelW'(256);

  typedef enum logic [CfgIdxW-1:0] {
    CfgLevelNone = 3'd0,
    CfgLevelOne  = 3'd1,
    CfgLevelTwo  = 3'd2,
    CfgLevelFull = 3'd3,
    CfgGain      = 3'd4
  } cfg_idx_e;

  typedef enum logic [FaceW-1:0] {
    FaceLeft  = 3'd0,
    FaceRight = 3'd1,
    FaceDown  = 3'd2,
    FaceUp    = 3'd3,
    FaceBack  = 3'd4,
    FaceFront = 3'd5
  } face_e;

  typedef struct packed {
    logic [LevelW-1:0] level_none;
    logic [LevelW-1:0] level_one;
    logic [LevelW-1:0] level_two;
    logic [LevelW-1:0] level_full;
    logic [LevelW-1:0] gain;
  } cfg_t;

  typedef struct packed {
    logic                        valid;
    logic [MaskW-1:0]            mask;
    logic [FaceW-1:0]            face;
    logic [VtxW-1:0]             vtx;
    logic [NumChan-1:0][ChanW-1:0] chan;
  } issue_t;

  typedef struct packed {
    logic [TapW-1:0] side1;
    logic [TapW-1:0] side2;
    logic [TapW-1:0] corner;
  } tap_t;

  // side1, side2, corner bit positions per face and vertex
  localparam tap_t TapTab [NumFace][NumVtx] = '{
    '{ '{5'd1,  5'd3,  5'd0},  '{5'd1,  5'd5,  5'd2},
       '{5'd7,  5'd5,  5'd8},  '{5'd7,  5'd3,  5'd6}  },
    '{ '{5'd19, 5'd21, 5'd18}, '{5'd19, 5'd23, 5'd20},
       '{5'd25, 5'd23, 5'd26}, '{5'd25, 5'd21, 5'd24} },
    '{ '{5'd1,  5'd9,  5'd0},  '{5'd1,  5'd11, 5'd2},
       '{5'd19, 5'd11, 5'd20}, '{5'd19, 5'd9,  5'd18} },
    '{ '{5'd7,  5'd15, 5'd6},  '{5'd7,  5'd17, 5'd8},
       '{5'd25, 5'd17, 5'd26}, '{5'd25, 5'd15, 5'd24} },
    '{ '{5'd3,  5'd9,  5'd0},  '{5'd3,  5'd15, 5'd6},
       '{5'd21, 5'd15, 5'd24}, '{5'd21, 5'd9,  5'd18} },
    '{ '{5'd5,  5'd11, 5'd2},  '{5'd5,  5'd17, 5'd8},
       '{5'd23, 5'd17, 5'd26}, '{5'd23, 5'd11, 5'd20} }
  };

  function automatic tap_t vertex_taps(input logic [FaceW-1:0] face,
                                       input logic [VtxW-1:0]  vtx);
    tap_t t;
    t = '0;
    if (face <= FaceFront) begin
      t = TapTab[face][vtx];
    end
    return t;
  endfunction

endpackage

// File: src/vfao_if.sv
// ----------------------------------------------------------------------------
// vfao interfaces
// Valid/ready channels of the voxel face AO shader: face items in, vertex
// results out, and the configuration write channel.
// ----------------------------------------------------------------------------
interface vfao_item_if import vfao_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MaskW-1:0] neighbor_mask;
  logic [FaceW-1:0] face;
  logic [ChanW-1:0] red_in;
  logic [ChanW-1:0] green_in;
  logic [ChanW-1:0] blue_in;

  modport source (output valid, neighbor_mask, face, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, neighbor_mask, face, red_in, green_in, blue_in,
                output ready);
endinterface

interface vfao_result_if import vfao_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VtxW-1:0]  vertex;
  logic [ChanW-1:0] red_out;
  logic [ChanW-1:0] green_out;
  logic [ChanW-1:0] blue_out;
  logic             last;

  modport source (output valid, vertex, red_out, green_out, blue_out, last,
                  input ready);
  modport sink (input valid, vertex, red_out, green_out, blue_out, last,
                output ready);
endinterface

interface vfao_cfg_if import vfao_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [LevelW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/vfao_pipe.sv
// ----------------------------------------------------------------------------
// vfao_pipe
// Four-stage shading pipeline: neighbour lookup and level pick, channel by
// level, by gain, then shift and saturate into the output register.
// ----------------------------------------------------------------------------
module vfao_pipe import vfao_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  issue_t           issue_i,
  input  logic             out_ready_i,
  output logic             adv_o,
  output logic             out_valid_o,
  output logic [VtxW-1:0]  vertex_o,
  output logic [NumChan-1:0][ChanW-1:0] chan_o,
  output logic             last_o
);

  logic                          s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic [VtxW-1:0]               s1_vtx_q, s2_vtx_q, s3_vtx_q, s4_vtx_q;
  logic [LevelW-1:0]             s1_level_q, s1_level_d;
  logic [NumChan-1:0][ChanW-1:0] s1_chan_q;
  logic [NumChan-1:0][ProdW-1:0] s2_prod_q, s2_prod_d;
  logic [NumChan-1:0][FullW-1:0] s3_full_q, s3_full_d;
  logic [NumChan-1:0][ChanW-1:0] s4_chan_q, s4_chan_d;
  tap_t                          tap;
  logic                          side1, side2, corner;
  logic [ShiftW-1:0]             shifted;

  assign adv_o = !s4_valid_q || out_ready_i;

  always_comb begin
    tap    = vertex_taps(issue_i.face, issue_i.vtx);
    side1  = issue_i.mask[tap.side1];
    side2  = issue_i.mask[tap.side2];
    corner = issue_i.mask[tap.corner];
    priority if (side1 && side2) begin
      s1_level_d = cfg_i.level_full;
    end else if ((side1 || side2) && corner) begin
      s1_level_d = cfg_i.level_two;
    end else if (side1 || side2 || corner) begin
      s1_level_d = cfg_i.level_one;
    end else begin
      s1_level_d = cfg_i.level_none;
    end
  end

  always_comb begin
    shifted = '0;
    for (int c = 0; c < NumChan; c++) begin
      s2_prod_d[c] = ProdW'(s1_chan_q[c]) * ProdW'(s1_level_q);
      s3_full_d[c] = FullW'(s2_prod_q[c]) * FullW'(cfg_i.gain);
      shifted      = s3_full_q[c][FullW-1:FracW];
      s4_chan_d[c] = (|shifted[ShiftW-1:ChanW]) ? '1 : shifted[ChanW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (adv_o) begin
      s1_valid_q <= issue_i.valid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      s1_vtx_q   <= issue_i.vtx;
      s1_level_q <= s1_level_d;
      s1_chan_q  <= issue_i.chan;
      s2_vtx_q   <= s1_vtx_q;
      s2_prod_q  <= s2_prod_d;
      s3_vtx_q   <= s2_vtx_q;
      s3_full_q  <= s3_full_d;
      s4_vtx_q   <= s3_vtx_q;
      s4_chan_q  <= s4_chan_d;
    end
  end

  assign out_valid_o = s4_valid_q;
  assign vertex_o    = s4_vtx_q;
  assign chan_o      = s4_chan_q;
  assign last_o      = (s4_vtx_q == LastVtx);

endmodule

// File: src/voxel_face_vertex_ao_shade.sv
// ----------------------------------------------------------------------------
// voxel_face_vertex_ao_shade
// Per-vertex ambient occlusion shading of one voxel face.
//
// item_i carries one face transaction: a 27-bit neighbour solid mask, the
// face code and a base RGB colour. result_o returns four vertex
// transactions per face, vertex 0 to 3, with last set on vertex 3. A face
// code of six or seven is accepted and produces no result. cfg_i writes
// the four shade levels and the gain; it is always ready. Write it only
// while the block is idle; the block itself does not enforce this.
// The accepted face is held in a holding register and issues its vertices
// in order into the shading pipeline. The single result channel emits one
// vertex per cycle while the receiver is ready; a new face is accepted
// in the cycle its predecessor issues its last vertex.
// Reset clears all valid bits and loads the level and gain defaults.
// When the receiver stalls, the whole pipeline holds and item_i drops
// ready once the holding register is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module voxel_face_vertex_ao_shade import vfao_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  vfao_item_if.sink     item_i,
  vfao_result_if.source result_o,
  vfao_cfg_if.sink      cfg_i
);

  cfg_t                          cfg_q, cfg_d;
  logic                          item_valid_q, item_valid_d;
  logic [MaskW-1:0]              mask_q;
  logic [FaceW-1:0]              face_q;
  logic [NumChan-1:0][ChanW-1:0] chan_q;
  logic [VtxW-1:0]               vtx_q, vtx_d;
  logic                          adv;
  logic                          issue_fire;
  logic                          last_issue;
  logic                          accept;
  issue_t                        issue;
  logic [NumChan-1:0][ChanW-1:0] out_chan;

  assign issue_fire   = item_valid_q && adv;
  assign last_issue   = issue_fire && (vtx_q == LastVtx);
  assign item_i.ready = !item_valid_q || last_issue;
  assign accept       = item_i.valid && item_i.ready;
  assign cfg_i.ready  = 1'b1;

  always_comb begin
    item_valid_d = item_valid_q;
    vtx_d        = vtx_q;
    if (accept) begin
      item_valid_d = (item_i.face <= FaceFront);
      vtx_d        = '0;
    end else if (last_issue) begin
      item_valid_d = 1'b0;
    end else if (issue_fire) begin
      vtx_d = vtx_q + VtxW'(1);
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgLevelNone: cfg_d.level_none = cfg_i.data;
        CfgLevelOne:  cfg_d.level_one  = cfg_i.data;
        CfgLevelTwo:  cfg_d.level_two  = cfg_i.data;
        CfgLevelFull: cfg_d.level_full = cfg_i.data;
        CfgGain:      cfg_d.gain       = cfg_i.data;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q     <= 1'b0;
      vtx_q            <= '0;
      cfg_q.level_none <= LevelNoneRst;
      cfg_q.level_one  <= LevelOneRst;
      cfg_q.level_two  <= LevelTwoRst;
      cfg_q.level_full <= LevelFullRst;
      cfg_q.gain       <= GainRst;
    end else begin
      item_valid_q <= item_valid_d;
      vtx_q        <= vtx_d;
      cfg_q        <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mask_q    <= item_i.neighbor_mask;
      face_q    <= item_i.face;
      chan_q[0] <= item_i.red_in;
      chan_q[1] <= item_i.green_in;
      chan_q[2] <= item_i.blue_in;
    end
  end

  always_comb begin
    issue.valid = item_valid_q;
    issue.mask  = mask_q;
    issue.face  = face_q;
    issue.vtx   = vtx_q;
    issue.chan  = chan_q;
  end

  vfao_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .issue_i     (issue),
    .out_ready_i (result_o.ready),
    .adv_o       (adv),
    .out_valid_o (result_o.valid),
    .vertex_o    (result_o.vertex),
    .chan_o      (out_chan),
    .last_o      (result_o.last)
  );

  assign result_o.red_out   = out_chan[0];
  assign result_o.green_out = out_chan[1];
  assign result_o.blue_out  = out_chan[2];

endmodule

// File: src/vfao_check.sv
// ----------------------------------------------------------------------------
// vfao_check
// Port-level checks of the voxel face AO shader, bound to the top level.
// ----------------------------------------------------------------------------
module vfao_check import vfao_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_valid_i,
  input logic             cfg_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [VtxW-1:0]  vertex_i,
  input logic [ChanW-1:0] red_i,
  input logic [ChanW-1:0] green_i,
  input logic [ChanW-1:0] blue_i,
  input logic             last_i
);

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(vertex_i)
      && $stable(red_i) && $stable(green_i) && $stable(blue_i) && $stable(last_i))
    else $error("stalled result transaction changed");

  a_last_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_i == (vertex_i == LastVtx)))
    else $error("last flag does not match final vertex");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("configuration write stalled");

endmodule

bind voxel_face_vertex_ao_shade vfao_check u_vfao_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .vertex_i    (result_o.vertex),
  .red_i       (result_o.red_out),
  .green_i     (result_o.green_out),
  .blue_i      (result_o.blue_out),
  .last_i      (result_o.last)
);

// File: test/voxel_face_vertex_ao_shade_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_vertex_ao_shade_test
// Drives face transactions with random neighbour masks, faces and colours
// through several shade level and gain settings. A scoreboard works out the
// four shaded vertices of each accepted face of code 0 to 5 and checks each
// vertex transaction in order, field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module voxel_face_vertex_ao_shade_test import vfao_pkg::*; ();

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned MaxReports  = 10;
  localparam logic [FaceW-1:0] FaceNoneLow  = 3'd6;
  localparam logic [FaceW-1:0] FaceNoneHigh = 3'd7;
  localparam logic [LevelW-1:0] LevelMax = '1;
  localparam logic [LevelW-1:0] LevelMin = '0;

  typedef struct packed {
    logic [VtxW-1:0]  vertex;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             last;
  } vertex_t;

  logic clk_i;
  logic rst_ni;
  bit   steady_flow;
  int unsigned idle_cycles;

  vfao_item_if   face_if ();
  vfao_result_if vtx_if ();
  vfao_cfg_if    cfg_if ();

  voxel_face_vertex_ao_shade dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (face_if),
    .result_o (vtx_if),
    .cfg_i    (cfg_if)
  );

  function automatic int unsigned nb_bit(int dx, int dy, int dz);
    return (dx + 1) * 9 + (dy + 1) * 3 + (dz + 1);
  endfunction

  // side1, side2 and corner bits of one vertex of one face
  function automatic void corner_taps(input logic [FaceW-1:0] face, input int v,
                                      output int unsigned s1, output int unsigned s2,
                                      output int unsigned cr);
    int a;
    int b;
    int s;
    a = (v < 2) ? -1 : 1;
    b = (v == 1 || v == 2) ? 1 : -1;
    s = face[0] ? 1 : -1;
    case (face)
      FaceLeft, FaceRight: begin
        s1 = nb_bit(s, a, 0);
        s2 = nb_bit(s, 0, b);
        cr = nb_bit(s, a, b);
      end
      FaceDown, FaceUp: begin
        s1 = nb_bit(a, s, 0);
        s2 = nb_bit(0, s, b);
        cr = nb_bit(a, s, b);
      end
      default: begin
        s1 = nb_bit(a, 0, s);
        s2 = nb_bit(0, b, s);
        cr = nb_bit(a, b, s);
      end
    endcase
  endfunction

  class vertex_scoreboard;
    cfg_t        regs;
    vertex_t     pending[$];
    int unsigned mismatches;

    function new();
      regs.level_none = LevelNoneRst;
      regs.level_one  = LevelOneRst;
      regs.level_two  = LevelTwoRst;
      regs.level_full = LevelFullRst;
      regs.gain       = GainRst;
      mismatches      = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [LevelW-1:0] value);
      case (idx)
        CfgLevelNone: regs.level_none = value;
        CfgLevelOne:  regs.level_one  = value;
        CfgLevelTwo:  regs.level_two  = value;
        CfgLevelFull: regs.level_full = value;
        CfgGain:      regs.gain       = value;
        default: ;
      endcase
    endfunction

    function logic [LevelW-1:0] occlusion_level(bit s1, bit s2, bit cr);
      int n;
      n = int'(s1) + int'(s2) + int'(cr);
      if ((s1 && s2) || n == 3) return regs.level_full;
      if (n == 2) return regs.level_two;
      if (n == 1) return regs.level_one;
      return regs.level_none;
    endfunction

    function logic [ChanW-1:0] shade_channel(logic [ChanW-1:0] ch, logic [LevelW-1:0] lvl);
      logic [31:0] p;
      p = 32'(ch) * 32'(lvl) * 32'(regs.gain);
      p = p >> FracW;
      return (p > 32'd255) ? 8'hFF : p[ChanW-1:0];
    endfunction

    function void note_face(logic [MaskW-1:0] mask, logic [FaceW-1:0] face,
                            logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                            logic [ChanW-1:0] b);
      int unsigned s1;
      int unsigned s2;
      int unsigned cr;
      logic [LevelW-1:0] lvl;
      vertex_t exp_vtx;
      if (face > FaceFront) return;
      for (int v = 0; v < NumVtx; v++) begin
        corner_taps(face, v, s1, s2, cr);
        lvl = occlusion_level(mask[s1], mask[s2], mask[cr]);
        exp_vtx.vertex = VtxW'(v);
        exp_vtx.red    = shade_channel(r, lvl);
        exp_vtx.green  = shade_channel(g, lvl);
        exp_vtx.blue   = shade_channel(b, lvl);
        exp_vtx.last   = (VtxW'(v) == LastVtx);
        pending.push_back(exp_vtx);
      end
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= MaxReports) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t exp_vtx;
      if (pending.size() == 0) begin
        report($sformatf("unexpected vertex v=%0d rgb=%0d,%0d,%0d last=%0b",
                         got.vertex, got.red, got.green, got.blue, got.last));
        return;
      end
      exp_vtx = pending.pop_front();
      if (got.vertex !== exp_vtx.vertex || got.red !== exp_vtx.red ||
          got.green !== exp_vtx.green || got.blue !== exp_vtx.blue ||
          got.last !== exp_vtx.last) begin
        report($sformatf({"vertex exp v=%0d rgb=%0d,%0d,%0d last=%0b",
                          " got v=%0d rgb=%0d,%0d,%0d last=%0b"},
                         exp_vtx.vertex, exp_vtx.red, exp_vtx.green, exp_vtx.blue,
                         exp_vtx.last, got.vertex, got.red, got.green, got.blue, got.last));
      end
    endfunction
  endclass

  vertex_scoreboard sb = new();

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // receiver: random ready bursts, steady in the last part
  int unsigned ready_burst;
  always @(negedge clk_i) begin
    if (steady_flow) begin
      vtx_if.ready = 1'b1;
    end else if (ready_burst > 0) begin
      ready_burst--;
    end else begin
      vtx_if.ready = ($urandom_range(0, 2) != 0);
      ready_burst  = $urandom_range(1, 5) - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && vtx_if.valid && vtx_if.ready) begin
      sb.check_vertex('{vertex: vtx_if.vertex, red: vtx_if.red_out,
                        green: vtx_if.green_out, blue: vtx_if.blue_out,
                        last: vtx_if.last});
    end
  end

  // watchdog: count cycles without any transaction
  always @(posedge clk_i) begin
    if ((face_if.valid && face_if.ready) || (vtx_if.valid && vtx_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [LevelW-1:0] value);
    cfg_if.index = idx;
    cfg_if.data  = value;
    cfg_if.valid = 1'b1;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    sb.write_reg(idx, value);
    @(negedge clk_i);
  endtask

  task automatic set_levels(logic [LevelW-1:0] none_lvl, logic [LevelW-1:0] one_lvl,
                            logic [LevelW-1:0] two_lvl, logic [LevelW-1:0] full_lvl,
                            logic [LevelW-1:0] gain_lvl);
    write_reg(CfgLevelNone, none_lvl);
    write_reg(CfgLevelOne, one_lvl);
    write_reg(CfgLevelTwo, two_lvl);
    write_reg(CfgLevelFull, full_lvl);
    write_reg(CfgGain, gain_lvl);
    cfg_if.valid = 1'b0;
  endtask

  task automatic send_face(logic [MaskW-1:0] mask, logic [FaceW-1:0] face,
                           logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                           logic [ChanW-1:0] b);
    if (!steady_flow && $urandom_range(0, 3) == 0) begin
      face_if.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    face_if.neighbor_mask = mask;
    face_if.face          = face;
    face_if.red_in        = r;
    face_if.green_in      = g;
    face_if.blue_in       = b;
    face_if.valid         = 1'b1;
    do @(posedge clk_i); while (!(face_if.valid && face_if.ready));
    sb.note_face(mask, face, r, g, b);
    @(negedge clk_i);
  endtask

  // drop valid, drain all expected vertices, then let the pipeline empty
  task automatic settle();
    face_if.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [ChanW-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return ChanW'($urandom);
    endcase
  endfunction

  function automatic logic [MaskW-1:0] rand_mask();
    case ($urandom_range(0, 5))
      0: return MaskW'($urandom & $urandom & $urandom);
      1: return MaskW'($urandom | $urandom);
      2: return '0;
      3: return '1;
      default: return MaskW'($urandom);
    endcase
  endfunction

  task automatic send_random(int unsigned count);
    int unsigned sent;
    logic [FaceW-1:0] face;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 19) == 0) begin
        face = $urandom_range(0, 1) ? FaceNoneHigh : FaceNoneLow;
      end else begin
        face = FaceW'($urandom_range(FaceLeft, FaceFront));
        sent++;
      end
      send_face(rand_mask(), face, rand_chan(), rand_chan(), rand_chan());
    end
  endtask

  logic [LevelW-1:0] rand_lvl[5];
  int unsigned s1;
  int unsigned s2;
  int unsigned cr;

  initial begin
    rst_ni                = 1'b0;
    steady_flow           = 1'b0;
    face_if.valid         = 1'b0;
    face_if.neighbor_mask = '0;
    face_if.face          = FaceLeft;
    face_if.red_in        = '0;
    face_if.green_in      = '0;
    face_if.blue_in       = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = CfgLevelNone;
    cfg_if.data           = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed, with reset levels
    for (int f = FaceLeft; f <= FaceFront; f++) begin
      send_face('0, FaceW'(f), '1, '1, '1);
      send_face('1, FaceW'(f), '0, 8'h80, '1);
    end
    corner_taps(FaceLeft, 0, s1, s2, cr);
    send_face(MaskW'(1) << cr, FaceLeft, '1, 8'h55, 8'hAA);
    send_face(MaskW'(1) << s1, FaceLeft, '1, 8'h55, 8'hAA);
    send_face((MaskW'(1) << s1) | (MaskW'(1) << cr), FaceLeft, '1, 8'h55, 8'hAA);
    send_face((MaskW'(1) << s2) | (MaskW'(1) << cr), FaceLeft, '1, 8'h55, 8'hAA);
    send_face((MaskW'(1) << s1) | (MaskW'(1) << s2), FaceLeft, '1, 8'h55, 8'hAA);
    send_face((MaskW'(1) << s1) | (MaskW'(1) << s2) | (MaskW'(1) << cr), FaceLeft,
              '1, 8'h55, 8'hAA);
    send_face('1, FaceNoneLow, '1, '1, '1);
    send_face('1, FaceNoneHigh, '1, '1, '1);
    settle();

    // saturation at every level
    set_levels(LevelMax, LevelMax, LevelMax, LevelMax, LevelMax);
    send_random(70);
    settle();

    set_levels(LevelMin, LevelMin, LevelMin, LevelMin, LevelMin);
    send_random(35);
    settle();

    // distinct levels so that a wrong pick shows
    set_levels(10'd300, 10'd240, 10'd170, 10'd90, LevelMax);
    send_random(90);
    settle();

    for (int i = 0; i < 5; i++) rand_lvl[i] = LevelW'($urandom);
    set_levels(rand_lvl[0], rand_lvl[1], rand_lvl[2], rand_lvl[3], rand_lvl[4]);
    send_random(100);
    settle();

    for (int i = 0; i < 5; i++) rand_lvl[i] = LevelW'($urandom_range(64, 512));
    set_levels(rand_lvl[0], rand_lvl[1], rand_lvl[2], rand_lvl[3], rand_lvl[4]);
    steady_flow = 1'b1;
    send_random(95);
    settle();

    if (sb.pending.size() != 0) sb.report("vertices still expected at end of run");
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
